>>> src/pdisp_pkg.sv
// shared codes, field widths and result type of the priority dispatcher
package pdisp_pkg;

   localparam int CMD_W    = 2;
   localparam int HANDLE_W = 16;
   localparam int PREQ_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int PEND_W   = 5;

   localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPRIO  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

   localparam logic [1:0] MARK_FREE = 2'd0;
   localparam logic [1:0] MARK_WAIT = 2'd1;
   localparam logic [1:0] MARK_RUN  = 2'd2;

   typedef struct packed {
      logic                running_valid;
      logic [PEND_W-1:0]   pending_count;
      logic [PREQ_W-1:0]   task_priority;
      logic [HANDLE_W-1:0] task_out;
      logic [SLOT_W-1:0]   slot_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

>>> src/pdisp_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
module pdisp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pdisp_ctrl.sv
// command sequencer: table scans, dispatch decision, nesting and counters
module pdisp_ctrl #(
   parameter int SLOTS      = 16,
   parameter int NEST_DEPTH = 8,
   parameter int PRIO_BITS  = 8,
   localparam int SW        = $clog2(SLOTS),
   localparam int ENTRY_W   = PRIO_BITS + 2 + SW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [pdisp_pkg::CMD_W-1:0]      in_cmd,
   input  logic [pdisp_pkg::HANDLE_W-1:0]   in_handle,
   input  logic [pdisp_pkg::PREQ_W-1:0]     in_preq,
   input  logic                             out_free,
   output logic                             res_valid,
   output pdisp_pkg::rsp_type               res,
   output logic                             a_we,
   output logic [SW-1:0]                    a_waddr,
   output logic [ENTRY_W-1:0]               a_wdata,
   output logic [SW-1:0]                    a_raddr,
   input  logic [ENTRY_W-1:0]               a_rdata,
   output logic                             b_we,
   output logic [SW-1:0]                    b_waddr,
   output logic [pdisp_pkg::HANDLE_W-1:0]   b_wdata,
   output logic [SW-1:0]                    b_raddr,
   input  logic [pdisp_pkg::HANDLE_W-1:0]   b_rdata
);

   localparam int NW = $clog2(NEST_DEPTH + 1);
   localparam int WW = $clog2(SLOTS + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CSCAN = 3'd2;
   localparam logic [2:0] S_DSCAN = 3'd3;
   localparam logic [2:0] S_DDEC  = 3'd4;
   localparam logic [2:0] S_DREAD = 3'd5;
   localparam logic [2:0] S_FREAD = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0]                      state_ff, state_in;
   logic [pdisp_pkg::HANDLE_W-1:0]  handle_ff, handle_in;
   logic [PRIO_BITS-1:0]            preq_ff, preq_in;
   logic [SW:0]                     scan_ff, scan_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic [SW-1:0]                   chk_addr_ff, chk_addr_in;
   logic                            found_ff, found_in;
   logic [SW-1:0]                   best_ff, best_in;
   logic [PRIO_BITS-1:0]            best_prio_ff, best_prio_in;
   logic [PRIO_BITS-1:0]            cur_prio_ff, cur_prio_in;
   logic                            cur_valid_ff, cur_valid_in;
   logic [SW-1:0]                   cur_slot_ff, cur_slot_in;
   logic [NW-1:0]                   level_ff, level_in;
   logic [WW-1:0]                   wait_ff, wait_in;
   pdisp_pkg::rsp_type              res_ff, res_in;

   logic [PRIO_BITS-1:0]            preq_w;
   logic [PRIO_BITS-1:0]            a_prio;
   logic [1:0]                      a_mark;
   logic [SW-1:0]                   a_link;
   logic                            chk_last;
   logic                            scan_more;

   assign preq_w    = PRIO_BITS'(in_preq);
   assign a_prio    = a_rdata[PRIO_BITS-1:0];
   assign a_mark    = a_rdata[PRIO_BITS+1:PRIO_BITS];
   assign a_link    = a_rdata[ENTRY_W-1:PRIO_BITS+2];
   assign chk_last  = (chk_addr_ff == SW'(SLOTS - 1));
   assign scan_more = (scan_ff < (SW+1)'(SLOTS));

   function automatic pdisp_pkg::rsp_type make_res(
      input logic [pdisp_pkg::STATUS_W-1:0] status,
      input logic [SW-1:0]                  slot,
      input logic [pdisp_pkg::HANDLE_W-1:0] handle,
      input logic [PRIO_BITS-1:0]           prio,
      input logic [WW-1:0]                  pending,
      input logic                           running
   );
      pdisp_pkg::rsp_type r;
      r.status        = status;
      r.slot_index    = pdisp_pkg::SLOT_W'(slot);
      r.task_out      = handle;
      r.task_priority = pdisp_pkg::PREQ_W'(prio);
      r.pending_count = pdisp_pkg::PEND_W'(pending);
      r.running_valid = running;
      return r;
   endfunction

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;

   always_comb begin
      state_in     = state_ff;
      handle_in    = handle_ff;
      preq_in      = preq_ff;
      scan_in      = scan_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      cur_prio_in  = cur_prio_ff;
      cur_valid_in = cur_valid_ff;
      cur_slot_in  = cur_slot_ff;
      level_in     = level_ff;
      wait_in      = wait_ff;
      res_in       = res_ff;
      a_we         = 1'b0;
      a_waddr      = scan_ff[SW-1:0];
      a_wdata      = '0;
      a_raddr      = cur_slot_ff;
      b_we         = 1'b0;
      b_waddr      = chk_addr_ff;
      b_wdata      = handle_ff;
      b_raddr      = cur_slot_ff;

      // table scans issue one read a cycle, data checked in the cycle after
      if ((state_ff == S_CSCAN || state_ff == S_DSCAN) && scan_more) begin
         a_raddr      = scan_ff[SW-1:0];
         chk_valid_in = 1'b1;
         chk_addr_in  = scan_ff[SW-1:0];
         scan_in      = scan_ff + 1'b1;
      end

      case (state_ff)
         S_CLEAR: begin
            a_we    = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (scan_ff[SW-1:0] == SW'(SLOTS - 1)) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               handle_in = in_handle;
               preq_in   = preq_w;
               scan_in   = '0;
               found_in  = 1'b0;
               case (in_cmd)
                  pdisp_pkg::CMD_CREATE: begin
                     if (preq_w == '0) begin
                        res_in   = make_res(pdisp_pkg::ST_BADPRIO, '0, '0, '0,
                                            wait_ff, cur_valid_ff);
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_CSCAN;
                     end
                  end
                  pdisp_pkg::CMD_DISPATCH: begin
                     state_in = S_DSCAN;
                  end
                  pdisp_pkg::CMD_FINISH: begin
                     if (!cur_valid_ff) begin
                        res_in   = make_res(pdisp_pkg::ST_IDLE, '0, '0, '0,
                                            wait_ff, cur_valid_ff);
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_FREAD;
                     end
                  end
                  default: begin
                     res_in   = make_res(pdisp_pkg::ST_OK, '0, '0, '0,
                                         wait_ff, cur_valid_ff);
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_CSCAN: begin
            if (chk_valid_ff) begin
               if (a_prio == '0) begin
                  a_we     = 1'b1;
                  a_waddr  = chk_addr_ff;
                  a_wdata  = {SW'(0), pdisp_pkg::MARK_WAIT, preq_ff};
                  b_we     = 1'b1;
                  wait_in  = wait_ff + 1'b1;
                  res_in   = make_res(pdisp_pkg::ST_OK, chk_addr_ff, handle_ff,
                                      preq_ff, wait_ff + 1'b1, cur_valid_ff);
                  state_in = S_EMIT;
               end else if (chk_last) begin
                  res_in   = make_res(pdisp_pkg::ST_FULL, '0, '0, '0,
                                      wait_ff, cur_valid_ff);
                  state_in = S_EMIT;
               end
            end
         end
         S_DSCAN: begin
            if (chk_valid_ff) begin
               if (a_mark == pdisp_pkg::MARK_WAIT && a_prio != '0 &&
                   (!found_ff || a_prio < best_prio_ff)) begin
                  found_in     = 1'b1;
                  best_in      = chk_addr_ff;
                  best_prio_in = a_prio;
               end
               if (chk_addr_ff == cur_slot_ff) begin
                  cur_prio_in = a_prio;
               end
               if (chk_last) begin
                  state_in = S_DDEC;
               end
            end
         end
         S_DDEC: begin
            if (!found_ff || (cur_valid_ff && best_prio_ff >= cur_prio_ff)) begin
               res_in   = make_res(pdisp_pkg::ST_NONE, '0, '0, '0,
                                   wait_ff, cur_valid_ff);
               state_in = S_EMIT;
            end else if (cur_valid_ff && level_ff == NW'(NEST_DEPTH)) begin
               res_in   = make_res(pdisp_pkg::ST_OVERFLOW, '0, '0, '0,
                                   wait_ff, cur_valid_ff);
               state_in = S_EMIT;
            end else begin
               // the preempted slot is kept as the link of the new one
               a_we    = 1'b1;
               a_waddr = best_ff;
               a_wdata = {cur_slot_ff, pdisp_pkg::MARK_RUN, best_prio_ff};
               b_raddr = best_ff;
               if (cur_valid_ff) begin
                  level_in = level_ff + 1'b1;
               end
               cur_valid_in = 1'b1;
               cur_slot_in  = best_ff;
               if (wait_ff != '0) begin
                  wait_in = wait_ff - 1'b1;
               end
               state_in = S_DREAD;
            end
         end
         S_DREAD: begin
            res_in   = make_res(pdisp_pkg::ST_OK, best_ff, b_rdata, best_prio_ff,
                                wait_ff, 1'b1);
            state_in = S_EMIT;
         end
         S_FREAD: begin
            a_we    = 1'b1;
            a_waddr = cur_slot_ff;
            a_wdata = '0;
            res_in  = make_res(pdisp_pkg::ST_OK, cur_slot_ff, b_rdata, a_prio,
                               wait_ff, (level_ff != '0));
            if (level_ff != '0) begin
               level_in    = level_ff - 1'b1;
               cur_slot_in = a_link;
            end else begin
               cur_valid_in = 1'b0;
               cur_slot_in  = '0;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         chk_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         level_ff     <= '0;
         wait_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         chk_valid_ff <= chk_valid_in;
         found_ff     <= found_in;
         cur_valid_ff <= cur_valid_in;
         cur_slot_ff  <= cur_slot_in;
         level_ff     <= level_in;
         wait_ff      <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff    <= handle_in;
      preq_ff      <= preq_in;
      chk_addr_ff  <= chk_addr_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      cur_prio_ff  <= cur_prio_in;
      res_ff       <= res_in;
   end

   a_nest_needs_running: assert property (@(posedge clock) disable iff (reset)
      (level_ff != '0) |-> cur_valid_ff)
      else $error("nesting level set with nothing running");

   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      wait_ff <= WW'(SLOTS))
      else $error("waiting count beyond table size");

   a_badprio_fast: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && in_valid && in_cmd == pdisp_pkg::CMD_CREATE &&
       preq_w == '0) |=> (state_ff == S_EMIT && res_ff.status == pdisp_pkg::ST_BADPRIO))
      else $error("zero priority create not rejected");

   a_run_from_dispatch: assert property (@(posedge clock) disable iff (reset)
      $rose(cur_valid_ff) |-> ($past(state_ff) == S_DDEC))
      else $error("running task appeared outside dispatch");

endmodule

>>> src/preemptive_priority_dispatcher_top.sv
// top level of the preemptive priority dispatcher: slot memories, sequencer, result register
//
//  channel  dir  ports                                   beat contents
//  req      in   req_tvalid / req_tready / req_tdata     command, task_handle, priority_req
//  rsp      out  rsp_tvalid / rsp_tready / rsp_tdata     status, slot_index, task_out,
//                                                        task_priority, pending_count,
//                                                        running_valid
//
//  work: create scans the slot memory up to the first free slot, dispatch makes one full
//    pass over it at one read a cycle, also when refused; finish, zero-priority creates
//    and unused commands do no scan
//  reset: synchronous; afterwards a clearing pass zeroes the slot memory,
//    req_tready stays low until it is done
//  stalls: one result beat waits in the output register; the next command is taken while
//    it waits and finishes its work, then holds until the register frees up
module preemptive_priority_dispatcher_top #(
   parameter int SLOTS      = 16,
   parameter int NEST_DEPTH = 8,
   parameter int PRIO_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // command[1:0], task_handle[17:2], priority_req[25:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[2:0], slot_index[6:3], task_out[22:7],
                                    // task_priority[30:23], pending_count[35:31],
                                    // running_valid[36]
);

   localparam int SW      = $clog2(SLOTS);
   localparam int ENTRY_W = PRIO_BITS + 2 + SW;

   // slot memory a: {link to preempted slot, mark, priority}
   logic               a_we;
   logic [SW-1:0]      a_waddr;
   logic [ENTRY_W-1:0] a_wdata;
   logic [SW-1:0]      a_raddr;
   logic [ENTRY_W-1:0] a_rdata;

   // slot memory b: task handles, never cleared
   logic                             b_we;
   logic [SW-1:0]                    b_waddr;
   logic [pdisp_pkg::HANDLE_W-1:0]   b_wdata;
   logic [SW-1:0]                    b_raddr;
   logic [pdisp_pkg::HANDLE_W-1:0]   b_rdata;

   logic               res_valid;
   pdisp_pkg::rsp_type res;
   logic               out_free;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   pdisp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   pdisp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   pdisp_ram #(
      .WIDTH (pdisp_pkg::HANDLE_W),
      .DEPTH (SLOTS)
   ) u_handle_mem (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   pdisp_ctrl #(
      .SLOTS      (SLOTS),
      .NEST_DEPTH (NEST_DEPTH),
      .PRIO_BITS  (PRIO_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tdata[1:0]),
      .in_handle (req_tdata[17:2]),
      .in_preq   (req_tdata[25:18]),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .a_we      (a_we),
      .a_waddr   (a_waddr),
      .a_wdata   (a_wdata),
      .a_raddr   (a_raddr),
      .a_rdata   (a_rdata),
      .b_we      (b_we),
      .b_waddr   (b_waddr),
      .b_wdata   (b_wdata),
      .b_raddr   (b_raddr),
      .b_rdata   (b_rdata)
   );

   // register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

>>> tb/preemptive_priority_dispatcher_checker.sv
// checker for the priority dispatcher: slot-table model, expected-outcome queue, beat compare
`timescale 1ns / 100ps

module preemptive_priority_dispatcher_checker
   import pdisp_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int NEST_DEPTH = 8,
   parameter int PRIO_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          open_count
);

   // model of the slot table
   logic [15:0] slot_prio   [SLOTS];
   logic [1:0]  slot_mark   [SLOTS];
   logic [15:0] slot_handle [SLOTS];
   bit          cur_valid;
   int          cur_slot;
   int          nest_stack  [NEST_DEPTH];
   int          nest_level;
   int          waiting_total;

   rsp_type     outcome_q[$];
   int          mismatch_total;

   assign fail_count = mismatch_total;

   function automatic rsp_type schedule_outcome(logic [1:0] cmd, logic [15:0] handle,
                                                logic [7:0] preq_raw);
      rsp_type     r;
      int          best;
      bit          found;
      int          mask;
      logic [15:0] preq;
      int          s;
      r     = '0;
      mask  = (1 << PRIO_BITS) - 1;
      preq  = {8'd0, preq_raw} & mask[15:0];
      best  = 0;
      found = 0;
      case (cmd)
         CMD_CREATE: begin
            if (preq == 0) begin
               r.status = ST_BADPRIO;
            end else begin
               for (int i = 0; i < SLOTS; i++)
                  if (!found && slot_prio[i] == 0) begin
                     found = 1;
                     best  = i;
                  end
               if (!found) begin
                  r.status = ST_FULL;
               end else begin
                  slot_prio[best]   = preq;
                  slot_handle[best] = handle;
                  slot_mark[best]   = MARK_WAIT;
                  waiting_total++;
                  r.status        = ST_OK;
                  r.slot_index    = best[SLOT_W-1:0];
                  r.task_out      = handle;
                  r.task_priority = preq[PREQ_W-1:0];
               end
            end
         end
         CMD_DISPATCH: begin
            // lowest priority number wins, ties to the lowest slot
            for (int i = 0; i < SLOTS; i++)
               if (slot_mark[i] == MARK_WAIT && slot_prio[i] != 0 &&
                   (!found || slot_prio[i] < slot_prio[best])) begin
                  found = 1;
                  best  = i;
               end
            if (!found || (cur_valid && slot_prio[best] >= slot_prio[cur_slot])) begin
               r.status = ST_NONE;
            end else if (cur_valid && nest_level >= NEST_DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               if (cur_valid) begin
                  nest_stack[nest_level] = cur_slot;
                  nest_level++;
               end
               slot_mark[best] = MARK_RUN;
               cur_valid       = 1;
               cur_slot        = best;
               if (waiting_total > 0)
                  waiting_total--;
               r.status        = ST_OK;
               r.slot_index    = best[SLOT_W-1:0];
               r.task_out      = slot_handle[best];
               r.task_priority = slot_prio[best][PREQ_W-1:0];
            end
         end
         CMD_FINISH: begin
            if (!cur_valid) begin
               r.status = ST_IDLE;
            end else begin
               s               = cur_slot;
               r.status        = ST_OK;
               r.slot_index    = s[SLOT_W-1:0];
               r.task_out      = slot_handle[s];
               r.task_priority = slot_prio[s][PREQ_W-1:0];
               slot_prio[s]    = 0;
               slot_mark[s]    = MARK_FREE;
               if (nest_level > 0) begin
                  nest_level--;
                  cur_slot = nest_stack[nest_level] % SLOTS;
               end else begin
                  cur_valid = 0;
                  cur_slot  = 0;
               end
            end
         end
         default: r.status = ST_OK;
      endcase
      r.pending_count = waiting_total[PEND_W-1:0];
      r.running_valid = cur_valid;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_prio[i]   = '0;
            slot_mark[i]   = MARK_FREE;
            slot_handle[i] = '0;
         end
         cur_valid      = 0;
         cur_slot       = 0;
         nest_level     = 0;
         waiting_total  = 0;
         mismatch_total = 0;
         outcome_q.delete();
      end else begin
         // result side first, so a beat never meets an outcome queued this edge
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (outcome_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected result beat %h at %0t", rsp_tdata, $realtime);
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status || got.slot_index !== want.slot_index ||
                   got.task_out !== want.task_out ||
                   got.task_priority !== want.task_priority ||
                   got.pending_count !== want.pending_count ||
                   got.running_valid !== want.running_valid) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  expected st=%0d slot=%0d task=%h prio=%0d pend=%0d run=%0d",
                              want.status, want.slot_index, want.task_out,
                              want.task_priority, want.pending_count, want.running_valid);
                     $display("  got      st=%0d slot=%0d task=%h prio=%0d pend=%0d run=%0d",
                              got.status, got.slot_index, got.task_out,
                              got.task_priority, got.pending_count, got.running_valid);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(schedule_outcome(req_tdata[1:0], req_tdata[17:2],
                                                 req_tdata[25:18]));
      end
      open_count <= outcome_q.size();
   end

endmodule

>>> tb/preemptive_priority_dispatcher_top_test.sv
// stimulus and verdict for the preemptive priority dispatcher
`timescale 1ns / 100ps

module preemptive_priority_dispatcher_top_test;
   import pdisp_pkg::*;

   // command code the block accepts but does nothing with
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // cycles with no beat on either side before the run is given up; the longest
   // correct quiet spell is a receiver hold-off plus one dispatch pass
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // command[1:0], task_handle[17:2], priority_req[25:18]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // status[2:0], slot_index[6:3], task_out[22:7],
                                   // task_priority[30:23], pending_count[35:31],
                                   // running_valid[36]

   int fail_count;
   int open_count;
   int cycle_count  = 0;
   int quiet_cycles = 0;

   preemptive_priority_dispatcher_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   preemptive_priority_dispatcher_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // free-running cycle count, read at the falling edge by both drivers
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog: any beat on either side resets the quiet count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL preemptive_priority_dispatcher_top");
      $finish;
   end

   // stretch of the run in which neither side idles
   function automatic bit steady_window();
      return cycle_count >= 6000 && cycle_count < 9000;
   endfunction

   // receiver: random back-pressure, plus two long hold-offs that fill the block
   // up while the sender keeps offering beats
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (cycle_count == 3000 || cycle_count == 12000)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady_window()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 6);
         end
      end
   end

   // offer one command beat and hold it until the block takes it; valid only
   // drops on an idle cycle, never between back-to-back beats
   task automatic offer_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
                                logic [PREQ_W-1:0] prio);
      @(negedge clock);
      while (!steady_window() && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, prio, handle, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender stands back until every outstanding result has come home
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (open_count != 0)
         @(negedge clock);
   endtask

   // one random command; weights steer the table towards full or empty
   task automatic offer_random(int create_w, int dispatch_w);
      int               pick;
      int               kind;
      logic [CMD_W-1:0] cmd;
      logic [7:0]       prio;
      pick = $urandom_range(99);
      if (pick < 2)
         cmd = CMD_SPARE;
      else if (pick < 2 + create_w)
         cmd = CMD_CREATE;
      else if (pick < 2 + create_w + dispatch_w)
         cmd = CMD_DISPATCH;
      else
         cmd = CMD_FINISH;
      // narrow priorities give plenty of ties, the odd zero is a rejected create
      kind = $urandom_range(99);
      if (kind < 3)
         prio = 8'd0;
      else if (kind < 30)
         prio = 8'($urandom_range(8, 1));
      else
         prio = 8'($urandom_range(255, 1));
      offer_command(cmd, 16'($urandom), prio);
   endtask

   initial begin
      int create_w;
      int dispatch_w;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // errors on an empty table and the spare command code
      offer_command(CMD_CREATE, 16'h1234, 8'd0);
      offer_command(CMD_DISPATCH, 16'hA5A5, 8'd7);
      offer_command(CMD_FINISH, 16'h5A5A, 8'd9);
      offer_command(CMD_SPARE, 16'hFFFF, 8'hFF);

      // nine tasks, each more urgent than the last, each preempting the one before;
      // that leaves the nesting stack full
      for (int lvl = 0; lvl < 9; lvl++) begin
         offer_command(CMD_CREATE,
                       (lvl == 0) ? 16'hFFFF : (lvl == 8) ? 16'h0000 : 16'($urandom),
                       8'(255 - lvl * 30));
         offer_command(CMD_DISPATCH, 16'($urandom), 8'($urandom));
      end
      // most urgent task yet, but there is no room left to nest it
      offer_command(CMD_CREATE, 16'h8001, 8'd1);
      offer_command(CMD_DISPATCH, 16'h0000, 8'd0);

      // fill the remaining slots, then one create too many
      for (int k = 0; k < 7; k++)
         offer_command(CMD_CREATE, 16'($urandom), 8'($urandom_range(255, 1)));

      // random part in phases: create-heavy, balanced, finish-heavy
      for (int phase = 0; phase < 9; phase++) begin
         case (phase % 3)
            0: begin
               create_w   = 50;
               dispatch_w = 30;
            end
            1: begin
               create_w   = 35;
               dispatch_w = 35;
            end
            default: begin
               create_w   = 20;
               dispatch_w = 30;
            end
         endcase
         for (int n = 0; n < 100; n++)
            offer_random(create_w, dispatch_w);
         if (phase == 3 || phase == 6)
            wait_drained();
      end

      // let the last beats come home, then a little longer for stragglers
      wait_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("PASS preemptive_priority_dispatcher_top");
      else
         $display("FAIL preemptive_priority_dispatcher_top");
      $finish;
   end

endmodule
